>>> sv/ppsi_pkg.sv
// Package for the point-code pair statistics block: sizes, codes, item types
// and shared helper functions. No dependencies.
package ppsi_pkg;

  // Table sizing.
  localparam int MAX_PAIRS    = 64;
  localparam int NUM_SI_CODES = 16;

  localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int IDX_W  = $clog2(MAX_PAIRS + 1);
  localparam int CODE_W = (NUM_SI_CODES > 1) ? $clog2(NUM_SI_CODES) : 1;
  localparam int CNT_DEPTH = MAX_PAIRS * NUM_SI_CODES;
  localparam int CNT_AW = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

  // Key word is {origin, dest}; counter word is {messages, bytes}.
  localparam int PC_W  = 24;
  localparam int KEY_W = 2 * PC_W;
  localparam int CTR_W = 32;
  localparam int CNT_W = 2 * CTR_W;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_RECORD = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_BAD_CODE = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  typedef struct packed {
    logic [1:0]      func;
    logic [PC_W-1:0] origin_pc;
    logic [PC_W-1:0] dest_pc;
    logic [7:0]      si_code;
    logic [15:0]     msg_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [5:0]       entry_slot;
    logic [CTR_W-1:0] msg_count;
    logic [CTR_W-1:0] byte_count;
  } out_result_t;

  // Access request to the key memory.
  typedef struct packed {
    logic              we;
    logic [PAIR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [PAIR_W-1:0] raddr;
  } key_port_t;

  // Access request to the counter memory.
  typedef struct packed {
    logic              we;
    logic [CNT_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic              re;
    logic [CNT_AW-1:0] raddr;
  } cnt_port_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_CNT_RD,
    S_CNT_WR,
    S_QUERY
  } ctrl_state_t;

  // Saturating 32-bit add.
  function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
                                               input logic [CTR_W-1:0] b);
    logic [CTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CTR_W] ? {CTR_W{1'b1}} : s[CTR_W-1:0];
  endfunction

  // Counter memory address of one entry and code.
  function automatic logic [CNT_AW-1:0] cnt_addr(input logic [PAIR_W-1:0] entry,
                                                 input logic [CODE_W-1:0] code);
    return CNT_AW'(int'(entry) * NUM_SI_CODES + int'(code));
  endfunction

endpackage

>>> sv/ppsi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ppsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ppsi_ctrl.sv
// Sequencer of the statistics block: key search, entry allocation, counter
// read-modify-write and query summation. Depends on ppsi_pkg.
module ppsi_ctrl
  import ppsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_result_t      out_result,
  output key_port_t        key_port,
  input  logic [KEY_W-1:0] key_rdata,
  output cnt_port_t        cnt_port,
  input  logic [CNT_W-1:0] cnt_rdata
);

  ctrl_state_t       state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  used_r, used_nxt;
  logic              pend_r, pend_nxt;
  logic [PAIR_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [PAIR_W-1:0] slot_r, slot_nxt;
  logic [CODE_W-1:0] sweep_r, sweep_nxt;
  logic [CTR_W-1:0]  acc_msg_r, acc_msg_nxt;
  logic [CTR_W-1:0]  acc_byte_r, acc_byte_nxt;
  out_result_t       res_r, res_nxt;
  logic              strobe_r, strobe_nxt;

  logic              accept;
  logic              in_bad;
  logic [CODE_W-1:0] code;
  logic              issue;
  logic              key_hit;
  logic              scan_done;
  logic              table_full;
  logic              sweep_last;
  logic [CTR_W-1:0]  bytes_ext;
  logic [CTR_W-1:0]  rd_msg;
  logic [CTR_W-1:0]  rd_byte;
  logic [CTR_W-1:0]  new_msg;
  logic [CTR_W-1:0]  new_byte;

  // Status decode shared by both combinational blocks.
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign in_bad     = ({1'b0, in_item.si_code} >= 9'(NUM_SI_CODES));
  assign code       = item_r.si_code[CODE_W-1:0];
  assign issue      = (ptr_r < used_r);
  assign key_hit    = pend_r && (key_rdata == {item_r.origin_pc, item_r.dest_pc});
  assign scan_done  = !issue && !pend_r;
  assign table_full = (used_r == IDX_W'(MAX_PAIRS));
  assign sweep_last = (sweep_r == CODE_W'(NUM_SI_CODES - 1));
  assign bytes_ext  = CTR_W'(item_r.msg_bytes);
  assign rd_msg     = cnt_rdata[CNT_W-1:CTR_W];
  assign rd_byte    = cnt_rdata[CTR_W-1:0];
  assign new_msg    = sat_add(rd_msg, CTR_W'(1));
  assign new_byte   = sat_add(rd_byte, bytes_ext);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_bad) begin
          if (in_item.func == FUNC_RECORD) begin
            state_nxt = S_SEARCH;
          end else if (in_item.func == FUNC_QUERY) begin
            state_nxt = S_QUERY;
          end
        end
      end
      S_SEARCH: begin
        if (key_hit) begin
          state_nxt = S_CNT_RD;
        end else if (scan_done) begin
          state_nxt = table_full ? S_IDLE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_CNT_RD: state_nxt = S_CNT_WR;
      S_CNT_WR: state_nxt = S_IDLE;
      S_QUERY: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory requests and result.
  always_comb begin
    item_nxt     = item_r;
    ptr_nxt      = ptr_r;
    used_nxt     = used_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    slot_nxt     = slot_r;
    sweep_nxt    = sweep_r;
    acc_msg_nxt  = acc_msg_r;
    acc_byte_nxt = acc_byte_r;
    res_nxt      = res_r;
    strobe_nxt   = 1'b0;
    key_port     = '0;
    cnt_port     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt     = in_item;
          ptr_nxt      = '0;
          sweep_nxt    = '0;
          acc_msg_nxt  = '0;
          acc_byte_nxt = '0;
          res_nxt      = '0;
          res_nxt.status = ST_DONE;
          // Clear, bad codes and unused functions finish at once.
          if (in_item.func == FUNC_CLEAR) begin
            used_nxt   = '0;
            strobe_nxt = 1'b1;
          end else if (in_item.func == FUNC_RECORD || in_item.func == FUNC_QUERY) begin
            if (in_bad) begin
              res_nxt.status = ST_BAD_CODE;
              strobe_nxt     = 1'b1;
            end
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        // One key read per cycle, compared in the cycle after.
        key_port.re    = issue && !key_hit;
        key_port.raddr = ptr_r[PAIR_W-1:0];
        if (key_port.re) begin
          ptr_nxt      = ptr_r + IDX_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r[PAIR_W-1:0];
        end
        if (key_hit) begin
          slot_nxt = pend_idx_r;
        end else if (scan_done) begin
          if (table_full) begin
            res_nxt        = '0;
            res_nxt.status = ST_FULL;
            strobe_nxt     = 1'b1;
          end else begin
            slot_nxt       = used_r[PAIR_W-1:0];
            key_port.we    = 1'b1;
            key_port.waddr = used_r[PAIR_W-1:0];
            key_port.wdata = {item_r.origin_pc, item_r.dest_pc};
            used_nxt       = used_r + IDX_W'(1);
          end
        end
      end
      S_ALLOC: begin
        // A new entry gets all its counters rewritten, the counted code with
        // its first message.
        cnt_port.we    = 1'b1;
        cnt_port.waddr = cnt_addr(slot_r, sweep_r);
        cnt_port.wdata = (sweep_r == code) ? {CTR_W'(1), bytes_ext} : '0;
        sweep_nxt      = sweep_r + CODE_W'(1);
        if (sweep_last) begin
          res_nxt.status     = ST_NEW;
          res_nxt.entry_slot = 6'(slot_r);
          res_nxt.msg_count  = CTR_W'(1);
          res_nxt.byte_count = bytes_ext;
          strobe_nxt         = 1'b1;
        end
      end
      S_CNT_RD: begin
        cnt_port.re    = 1'b1;
        cnt_port.raddr = cnt_addr(slot_r, code);
      end
      S_CNT_WR: begin
        cnt_port.we        = 1'b1;
        cnt_port.waddr     = cnt_addr(slot_r, code);
        cnt_port.wdata     = {new_msg, new_byte};
        res_nxt.status     = ST_EXISTING;
        res_nxt.entry_slot = 6'(slot_r);
        res_nxt.msg_count  = new_msg;
        res_nxt.byte_count = new_byte;
        strobe_nxt         = 1'b1;
      end
      S_QUERY: begin
        // Stream one entry's counters per cycle into the saturating sums.
        cnt_port.re    = issue;
        cnt_port.raddr = cnt_addr(ptr_r[PAIR_W-1:0], code);
        if (issue) begin
          ptr_nxt  = ptr_r + IDX_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          acc_msg_nxt  = sat_add(acc_msg_r, rd_msg);
          acc_byte_nxt = sat_add(acc_byte_r, rd_byte);
        end
        if (scan_done) begin
          res_nxt.status     = ST_DONE;
          res_nxt.entry_slot = '0;
          res_nxt.msg_count  = acc_msg_r;
          res_nxt.byte_count = acc_byte_r;
          strobe_nxt         = 1'b1;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ptr_r      <= ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    sweep_r    <= sweep_nxt;
    acc_msg_r  <= acc_msg_nxt;
    acc_byte_r <= acc_byte_nxt;
    res_r      <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = res_r;

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= IDX_W'(MAX_PAIRS))
    else $error("entry count exceeds table size");

  // The fill count only grows by one or drops to zero on a clear.
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (used_r != $past(used_r)) |->
      (used_r == '0) || (used_r == $past(used_r) + IDX_W'(1)))
    else $error("entry count moved by more than one");

  // A key is only written when allocating during a search with room left.
  a_key_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    key_port.we |-> (state_r == S_SEARCH) && !table_full)
    else $error("key written with no free entry");

  // No memory read is outstanding while idle.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("read in flight while idle");

endmodule

>>> sv/point_code_pair_si_statistics_top.sv
// Top level of the point-code pair statistics block: sequencer plus key and
// counter memories. Depends on ppsi_pkg, ppsi_ram and ppsi_ctrl.
//
// A transaction is taken when start is high and busy is low; every transaction
// gives exactly one result, shown for one cycle with out_strobe, and the
// receiver must take it then. A clear, an unused function or a bad code gives
// its result in the next cycle. A record searches the used entries at one key
// per cycle and, for a new pair, then rewrites the new entry's counters one
// code per cycle. A query reads one entry per cycle from the counter memory.
// The single read port of each memory sets these rates. No clearing pass is
// needed after reset or clear.
module point_code_pair_si_statistics_top
  import ppsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_result_t out_result
);

  key_port_t        key_port;
  cnt_port_t        cnt_port;
  logic [KEY_W-1:0] key_rdata;
  logic [CNT_W-1:0] cnt_rdata;

  // Sequencer.
  ppsi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .key_port   (key_port),
    .key_rdata  (key_rdata),
    .cnt_port   (cnt_port),
    .cnt_rdata  (cnt_rdata)
  );

  // Point-code pair keys, one word per entry.
  ppsi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_PAIRS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_port.we),
    .waddr (key_port.waddr),
    .wdata (key_port.wdata),
    .re    (key_port.re),
    .raddr (key_port.raddr),
    .rdata (key_rdata)
  );

  // Message and byte counters, one word per entry and code.
  ppsi_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_port.we),
    .waddr (cnt_port.waddr),
    .wdata (cnt_port.wdata),
    .re    (cnt_port.re),
    .raddr (cnt_port.raddr),
    .rdata (cnt_rdata)
  );

endmodule
